>>> rtl/assert_macros.svh
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PAF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("point attractor check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PAF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("point attractor check failed");

`endif

>>> rtl/paf_pkg.sv
package paf_pkg;

	localparam int COORD_W = 32;
	localparam int MUL_W   = 33;
	localparam int PROD_W  = 66;
	localparam int RAD_W   = 64;
	localparam int ROOT_W  = 32;
	localparam int DIVN_W  = 80;
	localparam int DIVD_W  = 66;
	localparam int DIVS_W  = 82;
	localparam int DIVQ_W  = 48;
	localparam int QCNT_W  = 6;
	localparam int FORCE_W = 16;
	localparam int PEAK_W  = 15;
	localparam int ENTRY_W = 4 * COORD_W;

	localparam logic [2:0] FUNC_APPEND = 3'd0;
	localparam logic [2:0] FUNC_WRITE  = 3'd1;
	localparam logic [2:0] FUNC_DEACT  = 3'd2;
	localparam logic [2:0] FUNC_CLEAR  = 3'd3;
	localparam logic [2:0] FUNC_QUERY  = 3'd4;

	localparam logic [2:0] CFG_ENGINE_ON  = 3'd0;
	localparam logic [2:0] CFG_GAIN       = 3'd1;
	localparam logic [2:0] CFG_DAMPING    = 3'd2;
	localparam logic [2:0] CFG_PULL_LIMIT = 3'd3;
	localparam logic [2:0] CFG_REACH_DEF  = 3'd4;
	localparam logic [2:0] CFG_MASS_FLOOR = 3'd5;
	localparam logic [2:0] CFG_MASS_CEIL  = 3'd6;

	localparam logic [RAD_W-1:0] NEAR_SQ     = 64'd429497;
	localparam logic [RAD_W-1:0] MIN_LEN_SQ  = 64'd269;
	localparam logic [RAD_W-1:0] UNIT_LEN_SQ = 64'd268435456;
	localparam logic [PEAK_W-1:0] ONE_Q14    = 15'd16384;

	localparam logic [QCNT_W-1:0] QB_PULL = 6'd17;
	localparam logic [QCNT_W-1:0] QB_WIDE = 6'd48;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD, ST_LOAD, ST_MA, ST_MB, ST_MC, ST_MD, ST_ME, ST_CHK,
		ST_SQ, ST_E2, ST_E2W, ST_DF, ST_FX, ST_FXW, ST_DVX, ST_FY, ST_FYW, ST_DVY,
		ST_L1, ST_L2, ST_L3, ST_LSQ, ST_SX, ST_DSX, ST_SY, ST_DSY, ST_OUT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [QCNT_W-1:0] qbits;
	} div_ctl_t;

	typedef struct packed {
		logic done;
		logic rem_nz;
	} sqrt_stat_t;

endpackage

>>> rtl/point_attractor_force_field.sv
// Point attractor force field. Table edits (append, write slot, deactivate,
// clear), rejected requests and queries with the engine off are taken while
// busy is low and answered in the next cycle, so they can arrive every cycle.
// A query holds busy high while it walks the table: unused or inactive slots
// are passed over, an active slot outside reach or too close is only tested,
// and a pulling slot runs the square root and the divider; then the net length
// is formed, and a sum longer than 1.0 takes another square root and two
// divides to scale it. The walk time is set by the shared
// restoring divider (one quotient bit per cycle, 48 bits per force component)
// and the one-bit-per-cycle square root. Each result is shown for exactly one
// cycle with done high and cannot be held off; capture it then. Configuration
// must be written only while no item is in flight.
module point_attractor_force_field #(
	parameter int ENTRIES = 16,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CNT_W = $clog2(ENTRIES + 1),
	localparam int SUM_W = 17 + CNT_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_addr,
	input  logic [31:0]                cfg_wdata,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 func,
	input  logic [7:0]                 slot,
	input  logic signed [31:0]         pos_x,
	input  logic signed [31:0]         pos_y,
	input  logic [31:0]                mass_in,
	input  logic [31:0]                capture_in,
	output logic                       done,
	output logic                       status,
	output logic [IDX_W-1:0]           slot_used,
	output logic [CNT_W-1:0]           entry_count,
	output logic signed [15:0]         force_x,
	output logic signed [15:0]         force_y,
	output logic [14:0]                peak_force,
	output logic                       captured,
	output logic [IDX_W-1:0]           captor_slot,
	output logic                       in_reach
);

	// configuration
	logic        engine_on_q;
	logic [31:0] gain_q, damp_q, reach_def_q, mfloor_q, mceil_q;
	logic [15:0] plimit_q;

	// table control
	paf_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0]   used_q, i_q;
	logic [ENTRIES-1:0] active_q;
	logic               done_q;

	// decode of an accepted item
	logic             acc, rej, we_a, we_b, set_act, pad, clr_one, clr_all;
	logic [IDX_W-1:0] wr_idx, used_out;
	logic [CNT_W-1:0] new_used;
	logic             slot_ok, slot_below, full;
	logic [31:0]      mass_cl;

	// memories
	logic [paf_pkg::ENTRY_W-1:0] ram_a_rd;
	logic [31:0]                 ram_b_rd;

	// query datapath
	logic signed [31:0]         px_q, py_q;
	logic signed [32:0]         dx_q, dy_q;
	logic [31:0]                mass_q, capr_q, reach_r_q, d_q;
	logic [63:0]                a_q, b_q, cap2_q, r2_q, num_q;
	logic [paf_pkg::PROD_W-1:0] prod_q;
	logic [15:0]                f_q, peak_q;
	logic signed [SUM_W-1:0]    sx_q, sy_q;
	logic [32:0]                len_q;
	logic                       status_q, captured_q, in_reach_q;
	logic [IDX_W-1:0]           slot_used_q, captor_q;
	logic signed [15:0]         fx_q, fy_q;

	logic [32:0]                ux, uy, e_val, mul_a, mul_b;
	logic [64:0]                s_sum;
	logic [63:0]                l2;
	logic                       skip, sat;
	logic [SUM_W-1:0]           sxm, sym, comp;
	logic [15:0]                qf;

	// shared units
	logic                            sq_start;
	logic [paf_pkg::RAD_W-1:0]       sq_rad;
	paf_pkg::sqrt_stat_t             sq_stat;
	logic [paf_pkg::ROOT_W-1:0]      sq_root;
	paf_pkg::div_ctl_t               dv_ctl;
	logic [paf_pkg::DIVN_W-1:0]      dv_num;
	logic [paf_pkg::DIVD_W-1:0]      dv_den;
	logic                            dv_done;
	logic [paf_pkg::DIVQ_W-1:0]      dv_quot;

	assign acc        = start && (state_q == paf_pkg::ST_IDLE);
	assign slot_ok    = int'(slot) < ENTRIES;
	assign slot_below = int'(slot) < int'(used_q);
	assign full       = int'(used_q) >= ENTRIES;

	always_comb begin
		mass_cl = (mass_in > mceil_q) ? mceil_q : mass_in;
		if (mass_cl < mfloor_q) begin
			mass_cl = mfloor_q;
		end
	end

	// item decode
	always_comb begin
		rej      = 1'b0;
		we_a     = 1'b0;
		we_b     = 1'b0;
		set_act  = 1'b0;
		pad      = 1'b0;
		clr_one  = 1'b0;
		clr_all  = 1'b0;
		wr_idx   = used_q[IDX_W-1:0];
		used_out = '0;
		new_used = used_q;
		unique case (func)
			paf_pkg::FUNC_APPEND: begin
				if (full) begin
					rej = 1'b1;
				end else begin
					we_a     = 1'b1;
					we_b     = 1'b1;
					set_act  = 1'b1;
					used_out = used_q[IDX_W-1:0];
					new_used = CNT_W'(used_q + 1'b1);
				end
			end
			paf_pkg::FUNC_WRITE: begin
				if (!slot_ok) begin
					rej = 1'b1;
				end else begin
					wr_idx   = slot[IDX_W-1:0];
					we_a     = 1'b1;
					set_act  = 1'b1;
					used_out = slot[IDX_W-1:0];
					if (!slot_below) begin
						// new tail: gap below it goes inactive, reach gets default
						we_b     = 1'b1;
						pad      = 1'b1;
						new_used = CNT_W'(slot[IDX_W-1:0]) + CNT_W'(1);
					end
				end
			end
			paf_pkg::FUNC_DEACT: begin
				if (!slot_below) begin
					rej = 1'b1;
				end else begin
					clr_one = 1'b1;
				end
			end
			paf_pkg::FUNC_CLEAR: begin
				clr_all  = 1'b1;
				new_used = '0;
			end
			paf_pkg::FUNC_QUERY: begin
			end
			default: begin
				rej = 1'b1;
			end
		endcase
	end

	// position, mass, capture radius in one word; reach kept apart since a
	// rewrite below the tail leaves it alone
	paf_ram #(.WIDTH(paf_pkg::ENTRY_W), .DEPTH(ENTRIES)) u_ram_a (
		.clk   (clk),
		.we    (acc && we_a),
		.waddr (wr_idx),
		.wdata ({pos_x, pos_y, mass_cl, capture_in}),
		.raddr (i_q[IDX_W-1:0]),
		.rdata (ram_a_rd)
	);

	paf_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_ram_b (
		.clk   (clk),
		.we    (acc && we_b),
		.waddr (wr_idx),
		.wdata (reach_def_q),
		.raddr (i_q[IDX_W-1:0]),
		.rdata (ram_b_rd)
	);

	paf_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.stat     (sq_stat),
		.root     (sq_root)
	);

	paf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dv_ctl),
		.dividend (dv_num),
		.divisor  (dv_den),
		.done     (dv_done),
		.quot     (dv_quot)
	);

	// combinational helpers
	assign ux    = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
	assign uy    = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
	assign s_sum = {1'b0, a_q} + {1'b0, b_q};
	// too far, outside reach, or closer than 0.01: no pull
	assign skip  = s_sum[64] || (s_sum[63:0] > r2_q) || (s_sum[63:0] < paf_pkg::NEAR_SQ);
	assign e_val = {1'b0, d_q} + {1'b0, damp_q};
	// pull quotient at or above 2^17 only ever lands on the limit
	assign sat   = {5'b0, num_q} >= {prod_q, 3'b000};
	assign sxm   = sx_q[SUM_W-1] ? SUM_W'(-sx_q) : SUM_W'(sx_q);
	assign sym   = sy_q[SUM_W-1] ? SUM_W'(-sy_q) : SUM_W'(sy_q);
	assign l2    = a_q + prod_q[63:0];
	assign comp  = SUM_W'(dv_quot[16:0]);
	assign qf    = dv_quot[15:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			paf_pkg::ST_IDLE: begin
				if (acc && (func == paf_pkg::FUNC_QUERY) && engine_on_q) begin
					state_d = paf_pkg::ST_RD;
				end
			end
			paf_pkg::ST_RD: begin
				if (i_q >= used_q) begin
					state_d = paf_pkg::ST_L1;
				end else if (active_q[i_q[IDX_W-1:0]]) begin
					state_d = paf_pkg::ST_LOAD;
				end
			end
			paf_pkg::ST_LOAD: state_d = paf_pkg::ST_MA;
			paf_pkg::ST_MA:   state_d = paf_pkg::ST_MB;
			paf_pkg::ST_MB:   state_d = paf_pkg::ST_MC;
			paf_pkg::ST_MC:   state_d = paf_pkg::ST_MD;
			paf_pkg::ST_MD:   state_d = paf_pkg::ST_ME;
			paf_pkg::ST_ME:   state_d = paf_pkg::ST_CHK;
			paf_pkg::ST_CHK:  state_d = skip ? paf_pkg::ST_RD : paf_pkg::ST_SQ;
			paf_pkg::ST_SQ: begin
				if (sq_stat.done) begin
					state_d = paf_pkg::ST_E2;
				end
			end
			paf_pkg::ST_E2:   state_d = paf_pkg::ST_E2W;
			paf_pkg::ST_E2W:  state_d = sat ? paf_pkg::ST_FX : paf_pkg::ST_DF;
			paf_pkg::ST_DF: begin
				if (dv_done) begin
					state_d = paf_pkg::ST_FX;
				end
			end
			paf_pkg::ST_FX:   state_d = paf_pkg::ST_FXW;
			paf_pkg::ST_FXW:  state_d = paf_pkg::ST_DVX;
			paf_pkg::ST_DVX: begin
				if (dv_done) begin
					state_d = paf_pkg::ST_FY;
				end
			end
			paf_pkg::ST_FY:   state_d = paf_pkg::ST_FYW;
			paf_pkg::ST_FYW:  state_d = paf_pkg::ST_DVY;
			paf_pkg::ST_DVY: begin
				if (dv_done) begin
					state_d = paf_pkg::ST_RD;
				end
			end
			paf_pkg::ST_L1:   state_d = paf_pkg::ST_L2;
			paf_pkg::ST_L2:   state_d = paf_pkg::ST_L3;
			paf_pkg::ST_L3: begin
				state_d = (l2 > paf_pkg::UNIT_LEN_SQ) ? paf_pkg::ST_LSQ : paf_pkg::ST_OUT;
			end
			paf_pkg::ST_LSQ: begin
				if (sq_stat.done) begin
					state_d = paf_pkg::ST_SX;
				end
			end
			paf_pkg::ST_SX:   state_d = paf_pkg::ST_DSX;
			paf_pkg::ST_DSX: begin
				if (dv_done) begin
					state_d = paf_pkg::ST_SY;
				end
			end
			paf_pkg::ST_SY:   state_d = paf_pkg::ST_DSY;
			paf_pkg::ST_DSY: begin
				if (dv_done) begin
					state_d = paf_pkg::ST_OUT;
				end
			end
			paf_pkg::ST_OUT:  state_d = paf_pkg::ST_IDLE;
			default:          state_d = paf_pkg::ST_IDLE;
		endcase
	end

	// unit controls and multiplier operands
	always_comb begin
		mul_a        = '0;
		mul_b        = '0;
		sq_start     = 1'b0;
		sq_rad       = s_sum[63:0];
		dv_ctl.start = 1'b0;
		dv_ctl.qbits = paf_pkg::QB_WIDE;
		dv_num       = paf_pkg::DIVN_W'(prod_q);
		dv_den       = paf_pkg::DIVD_W'(d_q);
		unique case (state_q)
			paf_pkg::ST_MA: begin
				mul_a = ux;
				mul_b = ux;
			end
			paf_pkg::ST_MB: begin
				mul_a = uy;
				mul_b = uy;
			end
			paf_pkg::ST_MC: begin
				mul_a = {1'b0, capr_q};
				mul_b = {1'b0, capr_q};
			end
			paf_pkg::ST_MD: begin
				mul_a = {1'b0, reach_r_q};
				mul_b = {1'b0, reach_r_q};
			end
			paf_pkg::ST_ME: begin
				mul_a = {1'b0, gain_q};
				mul_b = {1'b0, mass_q};
			end
			paf_pkg::ST_CHK: begin
				sq_start = !skip;
			end
			paf_pkg::ST_E2: begin
				mul_a = e_val;
				mul_b = e_val;
			end
			paf_pkg::ST_E2W: begin
				// F = gain * mass * 2^14 / e^2
				dv_ctl.start = !sat;
				dv_ctl.qbits = paf_pkg::QB_PULL;
				dv_num       = paf_pkg::DIVN_W'({num_q, 14'b0});
				dv_den       = prod_q;
			end
			paf_pkg::ST_FX: begin
				mul_a = ux;
				mul_b = 33'(f_q);
			end
			paf_pkg::ST_FY: begin
				mul_a = uy;
				mul_b = 33'(f_q);
			end
			paf_pkg::ST_FXW, paf_pkg::ST_FYW: begin
				dv_ctl.start = 1'b1;
			end
			paf_pkg::ST_L1: begin
				mul_a = 33'(sxm);
				mul_b = 33'(sxm);
			end
			paf_pkg::ST_L2: begin
				mul_a = 33'(sym);
				mul_b = 33'(sym);
			end
			paf_pkg::ST_L3: begin
				sq_start = l2 > paf_pkg::UNIT_LEN_SQ;
				sq_rad   = l2;
			end
			paf_pkg::ST_SX: begin
				dv_ctl.start = 1'b1;
				dv_num       = paf_pkg::DIVN_W'({sxm, 14'b0});
				dv_den       = paf_pkg::DIVD_W'(len_q);
			end
			paf_pkg::ST_SY: begin
				dv_ctl.start = 1'b1;
				dv_num       = paf_pkg::DIVN_W'({sym, 14'b0});
				dv_den       = paf_pkg::DIVD_W'(len_q);
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= paf_pkg::ST_IDLE;
			used_q      <= '0;
			active_q    <= '0;
			done_q      <= 1'b0;
			i_q         <= '0;
			engine_on_q <= 1'b1;
			gain_q      <= 32'd65536;
			damp_q      <= 32'd65536;
			plimit_q    <= 16'd16384;
			reach_def_q <= 32'd6553600;
			mfloor_q    <= 32'd6554;
			mceil_q     <= 32'd655360;
		end else begin
			state_q <= state_d;
			done_q  <= (acc && !((func == paf_pkg::FUNC_QUERY) && engine_on_q))
				|| (state_q == paf_pkg::ST_OUT);

			if (cfg_we) begin
				unique case (cfg_addr)
					paf_pkg::CFG_ENGINE_ON:  engine_on_q <= cfg_wdata[0];
					paf_pkg::CFG_GAIN:       gain_q      <= cfg_wdata;
					paf_pkg::CFG_DAMPING:    damp_q      <= cfg_wdata;
					paf_pkg::CFG_PULL_LIMIT: plimit_q    <= cfg_wdata[15:0];
					paf_pkg::CFG_REACH_DEF:  reach_def_q <= cfg_wdata;
					paf_pkg::CFG_MASS_FLOOR: mfloor_q    <= cfg_wdata;
					paf_pkg::CFG_MASS_CEIL:  mceil_q     <= cfg_wdata;
					default: begin
					end
				endcase
			end

			if (acc) begin
				used_q <= new_used;
				i_q    <= '0;
				if (clr_all) begin
					active_q <= '0;
				end else begin
					for (int k = 0; k < ENTRIES; k++) begin
						if (pad && (k >= int'(used_q)) && (k < int'(slot))) begin
							active_q[k] <= 1'b0;
						end
						if (set_act && (k == int'(wr_idx))) begin
							active_q[k] <= 1'b1;
						end
						if (clr_one && (k == int'(slot))) begin
							active_q[k] <= 1'b0;
						end
					end
				end
			end else if (((state_q == paf_pkg::ST_RD) && (i_q < used_q)
					&& !active_q[i_q[IDX_W-1:0]])
					|| ((state_q == paf_pkg::ST_CHK) && skip)
					|| ((state_q == paf_pkg::ST_DVY) && dv_done)) begin
				i_q <= i_q + CNT_W'(1);
			end
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		if (acc) begin
			px_q        <= pos_x;
			py_q        <= pos_y;
			status_q    <= rej;
			slot_used_q <= used_out;
			fx_q        <= '0;
			fy_q        <= '0;
			peak_q      <= '0;
			captured_q  <= 1'b0;
			captor_q    <= '0;
			in_reach_q  <= 1'b0;
			sx_q        <= '0;
			sy_q        <= '0;
		end

		unique case (state_q)
			paf_pkg::ST_LOAD: begin
				dx_q      <= {ram_a_rd[127], ram_a_rd[127:96]} - {px_q[31], px_q};
				dy_q      <= {ram_a_rd[95], ram_a_rd[95:64]} - {py_q[31], py_q};
				mass_q    <= ram_a_rd[63:32];
				capr_q    <= ram_a_rd[31:0];
				reach_r_q <= ram_b_rd;
			end
			paf_pkg::ST_MB:  a_q    <= prod_q[63:0];
			paf_pkg::ST_MC:  b_q    <= prod_q[63:0];
			paf_pkg::ST_MD:  cap2_q <= prod_q[63:0];
			paf_pkg::ST_ME:  r2_q   <= prod_q[63:0];
			paf_pkg::ST_CHK: begin
				num_q <= prod_q[63:0];
				// strict inside tests; first capturing slot wins
				if (!s_sum[64] && (s_sum[63:0] < cap2_q) && !captured_q) begin
					captured_q <= 1'b1;
					captor_q   <= i_q[IDX_W-1:0];
				end
				if (!s_sum[64] && (s_sum[63:0] < r2_q)) begin
					in_reach_q <= 1'b1;
				end
			end
			paf_pkg::ST_SQ: begin
				if (sq_stat.done) begin
					d_q <= sq_root;
				end
			end
			paf_pkg::ST_E2W: begin
				if (sat) begin
					f_q <= plimit_q;
				end
			end
			paf_pkg::ST_DF: begin
				if (dv_done) begin
					f_q <= (dv_quot[16:0] > {1'b0, plimit_q}) ? plimit_q : dv_quot[15:0];
				end
			end
			paf_pkg::ST_DVX: begin
				if (dv_done) begin
					sx_q <= dx_q[32] ? sx_q - $signed(comp) : sx_q + $signed(comp);
				end
			end
			paf_pkg::ST_DVY: begin
				if (dv_done) begin
					sy_q <= dy_q[32] ? sy_q - $signed(comp) : sy_q + $signed(comp);
					if (f_q > peak_q) begin
						peak_q <= f_q;
					end
				end
			end
			paf_pkg::ST_L2: a_q <= prod_q[63:0];
			paf_pkg::ST_L3: begin
				// short net pull vanishes, unit-or-less passes as is
				if (l2 < paf_pkg::MIN_LEN_SQ) begin
					fx_q <= '0;
					fy_q <= '0;
				end else begin
					fx_q <= sx_q[15:0];
					fy_q <= sy_q[15:0];
				end
			end
			paf_pkg::ST_LSQ: begin
				if (sq_stat.done) begin
					len_q <= {1'b0, sq_root} + 33'(sq_stat.rem_nz);
				end
			end
			paf_pkg::ST_DSX: begin
				if (dv_done) begin
					fx_q <= sx_q[SUM_W-1] ? -qf : qf;
				end
			end
			paf_pkg::ST_DSY: begin
				if (dv_done) begin
					fy_q <= sy_q[SUM_W-1] ? -qf : qf;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy        = state_q != paf_pkg::ST_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign slot_used   = slot_used_q;
	assign entry_count = used_q;
	assign force_x     = fx_q;
	assign force_y     = fy_q;
	assign peak_force  = (peak_q > 16'(paf_pkg::ONE_Q14)) ? paf_pkg::ONE_Q14
		: peak_q[paf_pkg::PEAK_W-1:0];
	assign captured    = captured_q;
	assign captor_slot = captor_q;
	assign in_reach    = in_reach_q;

endmodule

>>> rtl/paf_ram.sv
module paf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/paf_sqrt.sv
// Integer square root, one result bit per cycle; remainder flag for ceiling.
module paf_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [paf_pkg::RAD_W-1:0]    radicand,
	output paf_pkg::sqrt_stat_t          stat,
	output logic [paf_pkg::ROOT_W-1:0]   root
);

	logic [paf_pkg::RAD_W-1:0] v_q, r_q, bit_q, trial;
	logic run_q, done_q, ge;

	assign trial = r_q + bit_q;
	assign ge    = v_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && bit_q[0];
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[0]) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			r_q   <= '0;
			bit_q <= {2'b01, {(paf_pkg::RAD_W-2){1'b0}}};
		end else if (run_q) begin
			if (ge) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root        = r_q[paf_pkg::ROOT_W-1:0];
	assign stat.done   = done_q;
	assign stat.rem_nz = |v_q;

endmodule

>>> rtl/paf_div.sv
// Restoring divider, one quotient bit per cycle; caller guarantees the
// quotient fits the requested bit count.
module paf_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  paf_pkg::div_ctl_t           ctl,
	input  logic [paf_pkg::DIVN_W-1:0]  dividend,
	input  logic [paf_pkg::DIVD_W-1:0]  divisor,
	output logic                        done,
	output logic [paf_pkg::DIVQ_W-1:0]  quot
);

	logic [paf_pkg::DIVS_W-1:0] rem_q, dsh_q;
	logic [paf_pkg::QCNT_W-1:0] cnt_q;
	logic run_q, done_q, ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == paf_pkg::QCNT_W'(1));
			if (ctl.start) begin
				run_q <= 1'b1;
			end else if (run_q && (cnt_q == paf_pkg::QCNT_W'(1))) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= paf_pkg::DIVS_W'(dividend);
			dsh_q <= paf_pkg::DIVS_W'(divisor) << (ctl.qbits - paf_pkg::QCNT_W'(1));
			quot  <= '0;
			cnt_q <= ctl.qbits;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quot  <= {quot[paf_pkg::DIVQ_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
			cnt_q <= cnt_q - paf_pkg::QCNT_W'(1);
		end
	end

	assign done = done_q;

endmodule

>>> rtl/paf_chk.sv
`include "assert_macros.svh"

module paf_chk #(
	parameter int ENTRIES = 16,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CNT_W = $clog2(ENTRIES + 1)
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [2:0]         func,
	input logic               done,
	input logic               status,
	input logic [CNT_W-1:0]   entry_count,
	input logic signed [15:0] force_x,
	input logic signed [15:0] force_y,
	input logic [14:0]        peak_force,
	input logic               captured,
	input logic [IDX_W-1:0]   captor_slot,
	input logic               in_reach
);

	// results only come out once the walk is over
	`PAF_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`PAF_ASSERT_IMP(a_reject_quiet, clk, arst_n, done && status, force_x == 16'sd0 && force_y == 16'sd0 && !captured && !in_reach)
	`PAF_ASSERT_IMP(a_captor_zero, clk, arst_n, done && !captured, captor_slot == '0)
	`PAF_ASSERT_IMP(a_peak_cap, clk, arst_n, done, peak_force <= 15'd16384)
	`PAF_ASSERT_NXT(a_clear_next, clk, arst_n, start && !busy && func == paf_pkg::FUNC_CLEAR, done && !status && entry_count == '0)

endmodule

bind point_attractor_force_field paf_chk #(.ENTRIES(ENTRIES)) u_paf_chk (.*);

>>> tb/testbench.sv
module testbench;
	import paf_pkg::*;

	// One table edit or query, as driven on the input ports.
	typedef struct {
		logic [2:0]         func;
		logic [7:0]         slot;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [31:0]        mass;
		logic [31:0]        cap;
	} attr_item_t;

	// One answer, as seen on the result ports.
	typedef struct {
		logic               status;
		logic [3:0]         slot_used;
		logic [4:0]         count;
		logic signed [15:0] fx;
		logic signed [15:0] fy;
		logic [14:0]        peak;
		logic               captured;
		logic [3:0]         captor;
		logic               in_reach;
	} field_answer_t;

	localparam int NSLOT = 16;
	localparam longint CYCLE_LIMIT = 12_000_000;
	localparam int PHASES = 6;
	localparam int RAND_PER_PHASE = 165;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_addr;
	logic [31:0] cfg_wdata;
	logic start;
	logic busy;
	logic [2:0] func;
	logic [7:0] slot;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [31:0] mass_in;
	logic [31:0] capture_in;
	logic done;
	logic status;
	logic [3:0] slot_used;
	logic [4:0] entry_count;
	logic signed [15:0] force_x;
	logic signed [15:0] force_y;
	logic [14:0] peak_force;
	logic captured;
	logic [3:0] captor_slot;
	logic in_reach;

	point_attractor_force_field #(.ENTRIES(NSLOT)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy),
		.func(func), .slot(slot), .pos_x(pos_x), .pos_y(pos_y),
		.mass_in(mass_in), .capture_in(capture_in),
		.done(done), .status(status), .slot_used(slot_used),
		.entry_count(entry_count), .force_x(force_x), .force_y(force_y),
		.peak_force(peak_force), .captured(captured),
		.captor_slot(captor_slot), .in_reach(in_reach)
	);

	// Items waiting to be driven, answers waiting to come back.
	attr_item_t pending_items[$];
	field_answer_t expected_answers[$];
	int error_count = 0;
	int idle_pct = 0;
	logic item_taken = 1'b0;
	longint cycle_count = 0;

	// Predictor copy of the configuration registers.
	logic        p_engine;
	logic [31:0] p_gain, p_damp, p_reach_def, p_floor, p_ceil;
	logic [15:0] p_limit;

	// Predictor copy of the attractor table.
	logic signed [31:0] t_x[NSLOT], t_y[NSLOT];
	logic [31:0]        t_mass[NSLOT], t_cap[NSLOT], t_reach[NSLOT];
	logic               t_on[NSLOT];
	int                 t_used;

	// Generator-side shadow: slot count and which slots ever got a reach radius.
	// A write below the count onto a slot whose reach was never set would make
	// the block read an unwritten radius, so the generator steers away from it.
	int gen_used = 0;
	bit gen_reach_set[NSLOT];
	logic signed [31:0] gen_x[NSLOT], gen_y[NSLOT];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// Inverse-square pull of one slot in Q2.14, capped at pull_limit.
	function automatic longint unsigned slot_pull(input int i, input longint unsigned d);
		longint unsigned num, e, qa, t, f;
		num = p_gain;
		num = num * t_mass[i];
		e = d + p_damp;
		qa = num / e;
		if (qa >= (64'd1 << 36))
			f = 65536;
		else begin
			t = (qa << 14) + (((num % e) << 14) / e);
			f = t / e;
		end
		return (f > p_limit) ? longint'(p_limit) : f;
	endfunction

	function automatic logic [31:0] clamped_mass(input logic [31:0] m);
		logic [31:0] v;
		v = (m > p_ceil) ? p_ceil : m;
		return (v < p_floor) ? p_floor : v;
	endfunction

	function automatic void put_slot(input int i, input attr_item_t it, input bit fresh);
		t_x[i] = it.px;
		t_y[i] = it.py;
		t_mass[i] = clamped_mass(it.mass);
		t_cap[i] = it.cap;
		if (fresh)
			t_reach[i] = p_reach_def;
		t_on[i] = 1'b1;
	endfunction

	// Net pull, peak, capture and reach for a query point.
	function automatic void field_at(input attr_item_t it, inout field_answer_t r);
		longint sx, sy, dx, dy, fx, fy;
		longint unsigned ux, uy, cap2, r2, d, f, cx, cy, mx, my, l2, len;
		logic [64:0] s;
		longint unsigned peak;
		sx = 0;
		sy = 0;
		peak = 0;
		for (int i = 0; i < t_used && i < NSLOT; i++) begin
			if (!t_on[i])
				continue;
			dx = longint'(t_x[i]) - longint'(it.px);
			dy = longint'(t_y[i]) - longint'(it.py);
			ux = (dx < 0) ? -dx : dx;
			uy = (dy < 0) ? -dy : dy;
			s = {1'b0, ux * ux} + {1'b0, uy * uy};
			cap2 = t_cap[i];
			cap2 = cap2 * t_cap[i];
			r2 = t_reach[i];
			r2 = r2 * t_reach[i];
			if (!s[64] && s[63:0] < cap2 && !r.captured) begin
				r.captured = 1'b1;
				r.captor = i[3:0];
			end
			if (!s[64] && s[63:0] < r2)
				r.in_reach = 1'b1;
			if (s[64] || s[63:0] > r2 || s[63:0] < NEAR_SQ)
				continue;
			d = int_sqrt(s[63:0]);
			f = slot_pull(i, d);
			cx = ux * f / d;
			cy = uy * f / d;
			sx += (dx < 0) ? -longint'(cx) : longint'(cx);
			sy += (dy < 0) ? -longint'(cy) : longint'(cy);
			if (f > peak)
				peak = f;
		end
		mx = (sx < 0) ? -sx : sx;
		my = (sy < 0) ? -sy : sy;
		l2 = mx * mx + my * my;
		if (l2 < MIN_LEN_SQ) begin
			fx = 0;
			fy = 0;
		end else if (l2 <= UNIT_LEN_SQ) begin
			fx = sx;
			fy = sy;
		end else begin
			// length rounded up so the scaled vector never exceeds 1.0
			len = int_sqrt(l2);
			if (len * len != l2)
				len++;
			fx = longint'(mx * 16384 / len);
			fy = longint'(my * 16384 / len);
			if (sx < 0) fx = -fx;
			if (sy < 0) fy = -fy;
		end
		r.fx = fx[15:0];
		r.fy = fy[15:0];
		r.peak = (peak > 16384) ? ONE_Q14 : peak[14:0];
	endfunction

	// Applies one accepted item to the predictor and returns its answer.
	function automatic field_answer_t table_apply(input attr_item_t it);
		field_answer_t r;
		r = '{default: '0};
		case (it.func)
			FUNC_APPEND: begin
				if (t_used >= NSLOT)
					r.status = 1'b1;
				else begin
					r.slot_used = t_used[3:0];
					put_slot(t_used, it, 1'b1);
					t_used++;
				end
			end
			FUNC_WRITE: begin
				if (it.slot >= NSLOT)
					r.status = 1'b1;
				else begin
					r.slot_used = it.slot[3:0];
					if (it.slot < t_used)
						put_slot(it.slot, it, 1'b0);
					else begin
						for (int i = t_used; i < it.slot; i++)
							t_on[i] = 1'b0;
						put_slot(it.slot, it, 1'b1);
						t_used = it.slot + 1;
					end
				end
			end
			FUNC_DEACT: begin
				if (it.slot >= t_used)
					r.status = 1'b1;
				else
					t_on[it.slot] = 1'b0;
			end
			FUNC_CLEAR: begin
				t_used = 0;
				for (int i = 0; i < NSLOT; i++)
					t_on[i] = 1'b0;
			end
			FUNC_QUERY: begin
				if (p_engine)
					field_at(it, r);
			end
			default: r.status = 1'b1;
		endcase
		r.count = t_used[4:0];
		return r;
	endfunction

	// Queue an item, keeping the generator shadow in step and never
	// activating a slot with an unwritten reach radius.
	task automatic queue_item(input attr_item_t it);
		if (it.func == FUNC_WRITE && it.slot < gen_used && !gen_reach_set[it.slot]) begin
			if (gen_used < NSLOT)
				it.slot = gen_used[7:0];
			else
				it.func = FUNC_QUERY;
		end
		case (it.func)
			FUNC_APPEND: begin
				if (gen_used < NSLOT) begin
					gen_reach_set[gen_used] = 1'b1;
					gen_x[gen_used] = it.px;
					gen_y[gen_used] = it.py;
					gen_used++;
				end
			end
			FUNC_WRITE: begin
				if (it.slot < NSLOT) begin
					gen_x[it.slot] = it.px;
					gen_y[it.slot] = it.py;
					if (it.slot >= gen_used) begin
						gen_reach_set[it.slot] = 1'b1;
						gen_used = it.slot + 1;
					end
				end
			end
			FUNC_CLEAR: gen_used = 0;
			default: ;
		endcase
		pending_items.push_back(it);
	endtask

	function automatic logic signed [31:0] near_coord();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 75)
			return $signed($urandom_range(0, 80 << 16)) - (40 << 16);
		else if (pick < 92)
			return $urandom;
		else if (pick < 96)
			return 32'sh8000_0000;
		else
			return 32'sh7fff_ffff;
	endfunction

	function automatic attr_item_t make_item(input logic [2:0] f, input logic [7:0] s,
			input logic signed [31:0] x, input logic signed [31:0] y,
			input logic [31:0] m, input logic [31:0] c);
		attr_item_t it;
		it.func = f;
		it.slot = s;
		it.px = x;
		it.py = y;
		it.mass = m;
		it.cap = c;
		return it;
	endfunction

	function automatic attr_item_t random_item();
		attr_item_t it;
		int pick, k;
		it.px = near_coord();
		it.py = near_coord();
		it.mass = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20 << 16);
		it.cap = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 8 << 16);
		it.slot = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
			: $urandom_range(0, NSLOT - 1);
		pick = $urandom_range(0, 99);
		if (pick < 28)
			it.func = FUNC_APPEND;
		else if (pick < 42)
			it.func = FUNC_WRITE;
		else if (pick < 50)
			it.func = FUNC_DEACT;
		else if (pick < 53)
			it.func = FUNC_CLEAR;
		else if (pick < 96) begin
			it.func = FUNC_QUERY;
			// aim up to half of the queries near a known attractor to hit capture and near-field
			if (gen_used > 0 && $urandom_range(0, 99) < 50) begin
				k = $urandom_range(0, gen_used - 1);
				if (gen_reach_set[k]) begin
					it.px = gen_x[k] + $signed($urandom_range(0, 6 << 16)) - (3 << 16);
					it.py = gen_y[k] + $signed($urandom_range(0, 6 << 16)) - (3 << 16);
					if ($urandom_range(0, 9) == 0) begin
						it.px = gen_x[k];
						it.py = gen_y[k];
					end
				end
			end
		end else
			it.func = $urandom_range(5, 7);
		return it;
	endfunction

	// Register write: predictor copy and port, at a falling edge while idle.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
		case (idx)
			CFG_ENGINE_ON:  p_engine = v[0];
			CFG_GAIN:       p_gain = v;
			CFG_DAMPING:    p_damp = v;
			CFG_PULL_LIMIT: p_limit = v[15:0];
			CFG_REACH_DEF:  p_reach_def = v;
			CFG_MASS_FLOOR: p_floor = v;
			CFG_MASS_CEIL:  p_ceil = v;
			default: ;
		endcase
		cfg_addr <= idx;
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_answers.size() != 0 || start)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Driver: holds an item until the block takes it, then offers the next one.
	always @(negedge clk) begin
		attr_item_t it;
		if (arst_n && (!start || item_taken)) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				it = pending_items.pop_front();
				func <= it.func;
				slot <= it.slot;
				pos_x <= it.px;
				pos_y <= it.py;
				mass_in <= it.mass;
				capture_in <= it.cap;
				start <= 1'b1;
			end else
				start <= 1'b0;
		end
	end

	// Monitor: checks answers first; the item taken at this edge answers later.
	always @(posedge clk) begin
		field_answer_t e;
		attr_item_t it;
		cycle_count <= cycle_count + 1;
		if (done) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: answer with none expected (status %0d)", $time, status);
				error_count++;
			end else begin
				e = expected_answers.pop_front();
				if (status !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, status);
					error_count++;
				end
				if (slot_used !== e.slot_used) begin
					$display("%0t: slot_used exp %0d got %0d", $time, e.slot_used, slot_used);
					error_count++;
				end
				if (entry_count !== e.count) begin
					$display("%0t: entry_count exp %0d got %0d", $time, e.count, entry_count);
					error_count++;
				end
				if (force_x !== e.fx) begin
					$display("%0t: force_x exp %0d got %0d", $time, e.fx, force_x);
					error_count++;
				end
				if (force_y !== e.fy) begin
					$display("%0t: force_y exp %0d got %0d", $time, e.fy, force_y);
					error_count++;
				end
				if (peak_force !== e.peak) begin
					$display("%0t: peak_force exp %0d got %0d", $time, e.peak, peak_force);
					error_count++;
				end
				if (captured !== e.captured) begin
					$display("%0t: captured exp %0d got %0d", $time, e.captured, captured);
					error_count++;
				end
				if (captor_slot !== e.captor) begin
					$display("%0t: captor_slot exp %0d got %0d", $time, e.captor, captor_slot);
					error_count++;
				end
				if (in_reach !== e.in_reach) begin
					$display("%0t: in_reach exp %0d got %0d", $time, e.in_reach, in_reach);
					error_count++;
				end
			end
		end
		item_taken <= start && !busy;
		if (start && !busy) begin
			it.func = func;
			it.slot = slot;
			it.px = pos_x;
			it.py = pos_y;
			it.mass = mass_in;
			it.cap = capture_in;
			expected_answers.push_back(table_apply(it));
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		int idle_by_phase[PHASES];
		idle_by_phase = '{0, 51, 35, 0, 51, 35};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		start = 1'b0;
		func = '0;
		slot = '0;
		pos_x = '0;
		pos_y = '0;
		mass_in = '0;
		capture_in = '0;
		// reset values of the registers
		p_engine = 1'b1;
		p_gain = 32'd65536;
		p_damp = 32'd65536;
		p_limit = 16'd16384;
		p_reach_def = 32'd6553600;
		p_floor = 32'd6554;
		p_ceil = 32'd655360;
		t_used = 0;
		for (int i = 0; i < NSLOT; i++) begin
			t_on[i] = 1'b0;
			t_x[i] = '0;
			t_y[i] = '0;
			t_mass[i] = '0;
			t_cap[i] = '0;
			t_reach[i] = '0;
			gen_reach_set[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					write_reg(CFG_ENGINE_ON, 32'd1);
					write_reg(CFG_GAIN, 32'd65536);
					write_reg(CFG_DAMPING, 32'd65536);
					write_reg(CFG_PULL_LIMIT, 32'd16384);
					write_reg(CFG_REACH_DEF, 32'd6553600);
					write_reg(CFG_MASS_FLOOR, 32'd6554);
					write_reg(CFG_MASS_CEIL, 32'd655360);
				end
				1: begin
					// strongest settings: saturating pulls, unlimited reach
					write_reg(CFG_GAIN, 32'hffff_ffff);
					write_reg(CFG_DAMPING, 32'd0);
					write_reg(CFG_PULL_LIMIT, 32'hffff);
					write_reg(CFG_REACH_DEF, 32'hffff_ffff);
					write_reg(CFG_MASS_FLOOR, 32'd0);
					write_reg(CFG_MASS_CEIL, 32'hffff_ffff);
				end
				2: begin
					// no gain, no reach, ceiling below floor
					write_reg(CFG_GAIN, 32'd0);
					write_reg(CFG_DAMPING, 32'hffff_ffff);
					write_reg(CFG_PULL_LIMIT, 32'd0);
					write_reg(CFG_REACH_DEF, 32'd0);
					write_reg(CFG_MASS_FLOOR, 32'hffff_ffff);
					write_reg(CFG_MASS_CEIL, 32'd0);
				end
				3: begin
					write_reg(CFG_ENGINE_ON, 32'hffff_fffe);
					write_reg(CFG_GAIN, $urandom);
					write_reg(CFG_REACH_DEF, 32'd50 << 16);
				end
				4: begin
					write_reg(CFG_ENGINE_ON, 32'd1);
					write_reg(CFG_GAIN, 32'd3 << 16);
					write_reg(CFG_DAMPING, 32'd1 << 15);
					write_reg(CFG_PULL_LIMIT, 32'd8000);
					write_reg(CFG_REACH_DEF, 32'd20 << 16);
					write_reg(CFG_MASS_FLOOR, 32'd1 << 16);
					write_reg(CFG_MASS_CEIL, 32'd4 << 16);
				end
				default: begin
					write_reg(CFG_GAIN, $urandom_range(1 << 14, 1 << 22));
					write_reg(CFG_DAMPING, $urandom_range(0, 1 << 16));
					write_reg(CFG_PULL_LIMIT, $urandom_range(4000, 40000));
					write_reg(CFG_REACH_DEF, $urandom_range(10 << 16, 200 << 16));
					write_reg(CFG_MASS_FLOOR, $urandom_range(0, 1 << 16));
					write_reg(CFG_MASS_CEIL, $urandom_range(1 << 16, 30 << 16));
				end
			endcase
			idle_pct = idle_by_phase[ph];

			if (ph == 0) begin
				// directed: empty query, capture at the attractor, padding,
				// rejects, full table, coordinate extremes
				queue_item(make_item(FUNC_QUERY, 8'd0, 32'sd0, 32'sd0, 32'd0, 32'd0));
				queue_item(make_item(FUNC_APPEND, 8'd0, 32'sd0, 32'sd0, 32'd1 << 16, 32'd2 << 16));
				queue_item(make_item(FUNC_APPEND, 8'd0, 32'sd10 << 16, 32'sd0, 32'd0,
					32'd1 << 16));
				queue_item(make_item(FUNC_QUERY, 8'd0, 32'sd3 << 16, 32'sd0, 32'd0, 32'd0));
				queue_item(make_item(FUNC_QUERY, 8'd0, 32'sd0, 32'sd0, 32'd0, 32'd0));
				queue_item(make_item(FUNC_QUERY, 8'd0, 32'sd1 << 16, -32'sd1, 32'd0, 32'd0));
				queue_item(make_item(FUNC_WRITE, 8'd5, -32'sd5 << 16, 32'sd7 << 16,
					32'hffff_ffff, 32'd0));
				queue_item(make_item(FUNC_WRITE, 8'd1, 32'sd2 << 16, 32'sd2 << 16, 32'd0,
					32'hffff_ffff));
				queue_item(make_item(FUNC_QUERY, 8'd0, 32'sd1 << 16, 32'sd1 << 16, 32'd0, 32'd0));
				queue_item(make_item(FUNC_DEACT, 8'd1, 32'sd0, 32'sd0, 32'd0, 32'd0));
				queue_item(make_item(FUNC_DEACT, 8'd9, 32'sd0, 32'sd0, 32'd0, 32'd0));
				queue_item(make_item(FUNC_WRITE, 8'd16, 32'sd0, 32'sd0, 32'd0, 32'd0));
				queue_item(make_item(FUNC_WRITE, 8'd255, 32'sd0, 32'sd0, 32'd0, 32'd0));
				queue_item(make_item(3'd5, 8'd0, 32'sd0, 32'sd0, 32'd0, 32'd0));
				queue_item(make_item(3'd7, 8'hff, -32'sd1, -32'sd1, 32'hffff_ffff,
					32'hffff_ffff));
				queue_item(make_item(FUNC_APPEND, 8'd0, 32'sh8000_0000, 32'sh8000_0000,
					32'd3 << 16, 32'd0));
				queue_item(make_item(FUNC_QUERY, 8'd0, 32'sh7fff_ffff, 32'sh7fff_ffff,
					32'd0, 32'd0));
				for (int n = 0; n < 11; n++)
					queue_item(make_item(FUNC_APPEND, 8'd0, 32'sd4 << 16,
						$signed(n << 16), 32'd1 << 16, 32'd0));
				queue_item(make_item(FUNC_QUERY, 8'd0, 32'sd4 << 16, 32'sd20 << 16,
					32'd0, 32'd0));
				queue_item(make_item(FUNC_CLEAR, 8'd0, 32'sd0, 32'sd0, 32'd0, 32'd0));
				queue_item(make_item(FUNC_QUERY, 8'd0, 32'sd0, 32'sd0, 32'd0, 32'd0));
			end
			for (int n = 0; n < RAND_PER_PHASE; n++)
				queue_item(random_item());
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
